[design/piecewise_linear_sample_map_core_defines.svh]
// ----------------------------------------------------------------------------
// Piecewise-linear sample map assertion macros
// Shared assertion forms for the checker of the sample map core.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_SAMPLE_MAP_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_SAMPLE_MAP_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define PLSM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define PLSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/plsm_pkg.sv]
// ----------------------------------------------------------------------------
// Piecewise-linear sample map package
// Breakpoint tables, field widths and the item types shared by the core.
// ----------------------------------------------------------------------------
package plsm_pkg;

   // Number of breakpoints in use, limited to 2..16.
   localparam int BREAKPOINTS = 10;
   localparam int NPTS = (BREAKPOINTS < 2) ? 2 : ((BREAKPOINTS > 16) ? 16 : BREAKPOINTS);
   localparam int LAST = NPTS - 1;

   localparam int SAMPLE_W = 12;
   localparam int SIZE_W   = 12;
   localparam int SEG_W    = 4;
   localparam int PT_W     = 13;     // input points reach 4100
   localparam int OPT_W    = 12;     // output points reach 2100
   localparam int QUO_W    = OPT_W;  // quotient stays below the output span
   localparam int PROD_W   = PT_W + OPT_W;

   // The division by the input span of a segment is a multiplication by a
   // rounded-up reciprocal. The rounding excess of each reciprocal times the
   // largest product stays below 2^RECIP_K, so the high bits give the exact
   // floor of the quotient.
   localparam int RECIP_K  = 28;
   localparam int RECIP_W  = 22;
   localparam int SCALE_W  = PROD_W + RECIP_W;
   localparam longint RECIP_ONE = longint'(1) << RECIP_K;
   localparam logic [RECIP_W-1:0] RECIP_DEN500 = RECIP_W'((RECIP_ONE + 499) / 500);
   localparam logic [RECIP_W-1:0] RECIP_DEN100 = RECIP_W'((RECIP_ONE + 99) / 100);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam logic [SEG_W-1:0] LAST_IDX = SEG_W'(LAST);
   localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(LAST - 1);

   function automatic logic [PT_W-1:0] in_pt(input logic [SEG_W-1:0] idx);
      logic [PT_W-1:0] pt;
      unique case (idx)
         4'd0:    pt = PT_W'(0);
         4'd1:    pt = PT_W'(500);
         4'd2:    pt = PT_W'(1000);
         4'd3:    pt = PT_W'(1500);
         4'd4:    pt = PT_W'(2000);
         4'd5:    pt = PT_W'(2500);
         4'd6:    pt = PT_W'(3000);
         4'd7:    pt = PT_W'(3500);
         4'd8:    pt = PT_W'(4000);
         default: pt = PT_W'(4100);
      endcase
      return pt;
   endfunction

   function automatic logic [OPT_W-1:0] out_pt(input logic [SEG_W-1:0] idx);
      logic [OPT_W-1:0] pt;
      unique case (idx)
         4'd0:    pt = OPT_W'(1);
         4'd1:    pt = OPT_W'(20);
         4'd2:    pt = OPT_W'(60);
         4'd3:    pt = OPT_W'(120);
         4'd4:    pt = OPT_W'(250);
         4'd5:    pt = OPT_W'(300);
         4'd6:    pt = OPT_W'(500);
         4'd7:    pt = OPT_W'(800);
         4'd8:    pt = OPT_W'(1200);
         default: pt = OPT_W'(2100);
      endcase
      return pt;
   endfunction

   // Reciprocal of the input span of the segment that starts at idx.
   function automatic logic [RECIP_W-1:0] recip_pt(input logic [SEG_W-1:0] idx);
      logic [RECIP_W-1:0] m;
      unique case (idx) inside
         [4'd0:4'd7]: m = RECIP_DEN500;
         4'd8:        m = RECIP_DEN100;
         default:     m = '0;
      endcase
      return m;
   endfunction

   // A classified sample: base output, offset into the segment, output span
   // and the reciprocal of the input span of the segment.
   typedef struct packed {
      logic [SEG_W-1:0]   seg;
      logic [OPT_W-1:0]   base;
      logic [PT_W-1:0]    offset;
      logic [OPT_W-1:0]   span;
      logic [RECIP_W-1:0] recip;
   } front_item_type;

endpackage

[design/plsm_req_if.sv]
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries one converter sample per beat.
// ----------------------------------------------------------------------------
interface plsm_req_if;
   logic                           valid;
   logic                           ready;
   logic [plsm_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

[design/plsm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Mapped size response channel
// Valid/ready channel that carries one mapped size and its segment per beat.
// ----------------------------------------------------------------------------
interface plsm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [plsm_pkg::SIZE_W-1:0]   mapped_size;
   logic [plsm_pkg::SEG_W-1:0]    segment;

   modport source (output valid, output mapped_size, output segment, input ready);
   modport sink   (input valid, input mapped_size, input segment, output ready);
endinterface

[design/piecewise_linear_sample_map_core.sv]
// ----------------------------------------------------------------------------
// Piecewise-linear sample map core
// Maps twelve-bit converter samples through a fixed breakpoint curve.
// ----------------------------------------------------------------------------
// Usage:
// A sample enters on the req_if channel and leaves as one beat on the rsp_if
// channel with the interpolated size, rounded down, and the index of the
// lower breakpoint of the segment used. Results come out in sample order.
// The classifier registers a sample at the accepting edge; the item then
// passes through the queue, the offset-by-span multiplier, the reciprocal
// scaling and the output register that adds the segment base, which drives
// rsp_if.valid.
// Throughput is one sample per cycle while rsp_if.ready is high; the two
// multiplier stages set the latency. When the receiver holds off ready, the
// datapath freezes, the two-entry queue and the classifier register fill,
// and req_if.ready drops once both are full. The block keeps no state beyond
// the items in flight; reset empties the pipeline and the queue, and
// req_if.ready is high the cycle after.
// ----------------------------------------------------------------------------
module piecewise_linear_sample_map_core (
   input  logic        clock,
   input  logic        reset,
   plsm_req_if.sink    req_if,
   plsm_rsp_if.source  rsp_if
);

   logic                      front_valid;
   plsm_pkg::front_item_type  front_item;
   logic                      queue_ready;
   logic                      queue_valid;
   plsm_pkg::front_item_type  queue_item;
   logic                      back_take;

   plsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item_valid (front_valid),
      .item_out   (front_item),
      .item_take  (queue_ready)
   );

   plsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_ready (queue_ready),
      .pop_valid  (queue_valid),
      .pop_item   (queue_item),
      .pop_take   (back_take)
   );

   plsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_in    (queue_item),
      .item_take  (back_take),
      .rsp_if     (rsp_if)
   );

endmodule

[design/plsm_front.sv]
// ----------------------------------------------------------------------------
// Sample classifier
// Finds the segment of each accepted sample and registers its operands.
// ----------------------------------------------------------------------------
module plsm_front (
   input  logic                     clock,
   input  logic                     reset,
   plsm_req_if.sink                 req_if,
   output logic                     item_valid,
   output plsm_pkg::front_item_type item_out,
   input  logic                     item_take
);

   logic                          front_valid_ff;
   plsm_pkg::front_item_type      front_item_ff;
   plsm_pkg::front_item_type      front_item_in;
   logic [plsm_pkg::PT_W-1:0]     sample_ext;
   logic [plsm_pkg::SEG_W-1:0]    seg_sel;
   logic [plsm_pkg::SEG_W-1:0]    seg_nxt;
   logic                          below;
   logic                          above;

   assign req_if.ready = !front_valid_ff || item_take;

   always_comb begin
      sample_ext = {1'b0, req_if.sample};
      below = sample_ext < plsm_pkg::in_pt(4'd0);
      above = sample_ext >= plsm_pkg::in_pt(plsm_pkg::LAST_IDX);

      // Every segment is compared at once; the lowest match wins.
      seg_sel = '0;
      for (int i = plsm_pkg::LAST - 1; i >= 0; i--) begin
         if (plsm_pkg::in_pt(plsm_pkg::SEG_W'(i)) <= sample_ext &&
             sample_ext < plsm_pkg::in_pt(plsm_pkg::SEG_W'(i + 1))) begin
            seg_sel = plsm_pkg::SEG_W'(i);
         end
      end
      seg_nxt = seg_sel + plsm_pkg::SEG_W'(1);

      // Out-of-table samples are sent as an empty interpolation on the end point.
      front_item_in.offset = '0;
      front_item_in.span   = '0;
      front_item_in.recip  = '0;
      if (below) begin
         front_item_in.seg  = '0;
         front_item_in.base = plsm_pkg::out_pt(4'd0);
      end else if (above) begin
         front_item_in.seg  = plsm_pkg::LAST_SEG;
         front_item_in.base = plsm_pkg::out_pt(plsm_pkg::LAST_IDX);
      end else begin
         front_item_in.seg    = seg_sel;
         front_item_in.base   = plsm_pkg::out_pt(seg_sel);
         front_item_in.offset = sample_ext - plsm_pkg::in_pt(seg_sel);
         front_item_in.span   = plsm_pkg::out_pt(seg_nxt) - plsm_pkg::out_pt(seg_sel);
         front_item_in.recip  = plsm_pkg::recip_pt(seg_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         front_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         front_item_ff <= front_item_in;
      end
   end

   assign item_valid = front_valid_ff;
   assign item_out   = front_item_ff;

endmodule

[design/plsm_queue.sv]
// ----------------------------------------------------------------------------
// Classifier to datapath queue
// Two-entry queue that lets the classifier and the datapath stall apart.
// ----------------------------------------------------------------------------
module plsm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  plsm_pkg::front_item_type push_item,
   output logic                     push_ready,
   output logic                     pop_valid,
   output plsm_pkg::front_item_type pop_item,
   input  logic                     pop_take
);

   plsm_pkg::front_item_type       entry_ff [plsm_pkg::QUEUE_DEPTH];
   logic [plsm_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [plsm_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [plsm_pkg::QCNT_W-1:0]    count_ff;
   logic [plsm_pkg::QCNT_W-1:0]    count_in;
   logic                           push;
   logic                           pop;

   // Ready comes from the registered count only, so no path runs through.
   assign push_ready = count_ff < plsm_pkg::QCNT_W'(plsm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_take && pop_valid;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + plsm_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - plsm_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + plsm_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + plsm_pkg::QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/plsm_back.sv]
// ----------------------------------------------------------------------------
// Interpolation datapath
// Multiplies the segment offset by the output span, scales the product by
// the reciprocal of the input span and adds the segment base.
// ----------------------------------------------------------------------------
module plsm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  plsm_pkg::front_item_type item_in,
   output logic                     item_take,
   plsm_rsp_if.source               rsp_if
);

   logic                             advance;
   logic                             mul_valid_ff;
   logic [plsm_pkg::PROD_W-1:0]      mul_prod_ff;
   logic [plsm_pkg::RECIP_W-1:0]     mul_recip_ff;
   logic [plsm_pkg::OPT_W-1:0]       mul_base_ff;
   logic [plsm_pkg::SEG_W-1:0]       mul_seg_ff;
   logic [plsm_pkg::SCALE_W-1:0]     scale_prod;
   logic                             scale_valid_ff;
   logic [plsm_pkg::QUO_W-1:0]       scale_quo_ff;
   logic [plsm_pkg::OPT_W-1:0]       scale_base_ff;
   logic [plsm_pkg::SEG_W-1:0]       scale_seg_ff;
   logic                             out_valid_ff;
   logic [plsm_pkg::SIZE_W-1:0]      out_size_ff;
   logic [plsm_pkg::SEG_W-1:0]       out_seg_ff;
   logic [plsm_pkg::SIZE_W:0]        size_sum;

   // The whole datapath moves together whenever the output slot can drain.
   assign advance   = !out_valid_ff || rsp_if.ready;
   assign item_take = advance;

   // The quotient is the product scaled by the reciprocal, shifted down.
   assign scale_prod = plsm_pkg::SCALE_W'(mul_prod_ff) * plsm_pkg::SCALE_W'(mul_recip_ff);

   assign size_sum = {1'b0, scale_base_ff} + {1'b0, scale_quo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff   <= 1'b0;
         scale_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else if (advance) begin
         mul_valid_ff   <= item_valid;
         scale_valid_ff <= mul_valid_ff;
         out_valid_ff   <= scale_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_prod_ff   <= plsm_pkg::PROD_W'(item_in.offset) * plsm_pkg::PROD_W'(item_in.span);
         mul_recip_ff  <= item_in.recip;
         mul_base_ff   <= item_in.base;
         mul_seg_ff    <= item_in.seg;
         scale_quo_ff  <= scale_prod[plsm_pkg::RECIP_K+plsm_pkg::QUO_W-1:plsm_pkg::RECIP_K];
         scale_base_ff <= mul_base_ff;
         scale_seg_ff  <= mul_seg_ff;
         out_size_ff   <= size_sum[plsm_pkg::SIZE_W-1:0];
         out_seg_ff    <= scale_seg_ff;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.mapped_size = out_size_ff;
   assign rsp_if.segment     = out_seg_ff;

endmodule

[design/plsm_checker.sv]
// ----------------------------------------------------------------------------
// Sample map port checker
// Watches the ports of the core and flags range and ordering slips.
// ----------------------------------------------------------------------------
`include "piecewise_linear_sample_map_core_defines.svh"

module plsm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [plsm_pkg::SAMPLE_W-1:0] req_sample,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [plsm_pkg::SIZE_W-1:0]   rsp_mapped_size,
   input logic [plsm_pkg::SEG_W-1:0]    rsp_segment
);

   logic [plsm_pkg::SIZE_W-1:0] size_lo;
   logic [plsm_pkg::SIZE_W-1:0] size_hi;

   assign size_lo  = plsm_pkg::SIZE_W'(plsm_pkg::out_pt(4'd0));
   assign size_hi  = plsm_pkg::SIZE_W'(plsm_pkg::out_pt(plsm_pkg::LAST_IDX));

   // A stalled result beat holds its value.
   `PLSM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mapped_size) && $stable(rsp_segment), "response changed while stalled")

   // The segment never names the last breakpoint as a lower point.
   `PLSM_ASSERT(a_seg_range, clock, reset, rsp_valid |-> rsp_segment <= plsm_pkg::LAST_SEG, "segment out of range")

   // The curve is rising, so results stay between its end points.
   `PLSM_ASSERT(a_size_range, clock, reset, rsp_valid |-> rsp_mapped_size >= size_lo && rsp_mapped_size <= size_hi, "mapped size out of range")

   // Reset empties the pipeline and opens the input.
   `PLSM_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid && req_ready, "reset did not clear the pipeline")

   // A sample that waits for ready is held by the sender.
   `PLSM_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid && $stable(req_sample), "request changed while stalled")

endmodule

bind piecewise_linear_sample_map_core plsm_checker u_plsm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_sample      (req_if.sample),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_mapped_size (rsp_if.mapped_size),
   .rsp_segment     (rsp_if.segment)
);
